[rtl/xxh_pkg.sv]
// Shared types, constants and helpers for the streaming 64-bit xxHash block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package xxh_pkg;

    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    localparam logic [3:0] FULL_COUNT = 4'd8;
    localparam logic [1:0] STRIPE_HELD = 2'd3;
    localparam logic [1:0] LAST_LANE = 2'd3;

    // One classified input word as it sits in the queue.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  cnt;   // 0..8, forced to 8 for words that are not last
        logic        last;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RND_A,
        ST_RND_B,
        ST_FIN,
        ST_MERGE,
        ST_FL_A,
        ST_FL_B,
        ST_FL_C,
        ST_LEN,
        ST_PW_CHK,
        ST_PW_A,
        ST_PW_B,
        ST_PW_C,
        ST_Q_CHK,
        ST_Q_A,
        ST_Q_B,
        ST_B_CHK,
        ST_BY_A,
        ST_BY_B,
        ST_AV_A,
        ST_AV_B,
        ST_OUT
    } t_bstate;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    // Lane rotation used when the four accumulators are merged.
    function automatic logic [63:0] merge_rot(input logic [63:0] x, input logic [1:0] idx);
        logic [63:0] res;
        res = x;
        case (idx)
            2'd0: res = rotl(x, 1);
            2'd1: res = rotl(x, 7);
            2'd2: res = rotl(x, 12);
            default: res = rotl(x, 18);
        endcase
        merge_rot = res;
    endfunction

endpackage

`default_nettype wire

[rtl/xxhash64_stream_hasher.sv]
// Processing: a word that does not complete a stripe is held in the back end; a stripe
//   word runs four lane rounds of two multiplies each.
// A final word adds up to 31 multiplies, each run on the shared 3-step multiplier,
//   before the digest is produced.
// Throughput: one queued word per back-end pass; the two-entry input queue takes words
//   while the back end works. Digest is registered and held until taken.
// Reset (synchronous, active low) clears the queue, the message state and sets seed to zero.
`default_nettype none

module xxhash64_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Seed configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_cfg_data,
    // Message words in.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  wire logic        s_axis_tlast,   // last_word
    // Digest out.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [63:0] digest
);

    logic [63:0]        r_seed;
    logic               w_qvalid, w_pop;
    xxh_pkg::t_item     w_item;
    xxh_pkg::t_mul_req  w_mreq;
    xxh_pkg::t_mul_rsp  w_mrsp;

    // The seed register accepts a transaction in every cycle. The user must write it only
    // between messages (the block does not enforce this), so the back end reads it directly.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    // The front end classifies each word and queues it.
    xxh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_valid       (w_qvalid),
        .o_item        (w_item),
        .i_pop         (w_pop)
    );

    // The back end sequences all multiplies through one shared multiplier.
    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    xxh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seed   (r_seed),
        .i_valid  (w_qvalid),
        .i_item   (w_item),
        .o_pop    (w_pop),
        .o_mreq   (w_mreq),
        .i_mrsp   (w_mrsp),
        .o_valid  (m_axis_tvalid),
        .o_digest (m_axis_tdata),
        .i_ready  (m_axis_tready)
    );

endmodule

`default_nettype wire

[rtl/xxh_front.sv]
// Input side of the hasher: takes stream words, normalizes the byte count
// and holds them in a two-entry queue for the back end. Uses xxh_pkg.
`default_nettype none

module xxh_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [71:0]    s_axis_tdata,   // [63:0] data_word, [67:64] byte_count
    input  wire logic           s_axis_tlast,   // last_word
    output logic                o_valid,
    output xxh_pkg::t_item      o_item,
    input  wire logic           i_pop
);

    xxh_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    xxh_pkg::t_item w_cls;
    logic           w_push;

    // A word that is not last always counts as full, and counts above eight clamp.
    always_comb begin
        w_cls.word = s_axis_tdata[63:0];
        w_cls.last = s_axis_tlast;
        if (!s_axis_tlast || (s_axis_tdata[67:64] > xxh_pkg::FULL_COUNT)) begin
            w_cls.cnt = xxh_pkg::FULL_COUNT;
        end else begin
            w_cls.cnt = s_axis_tdata[67:64];
        end
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_valid       = (r_cnt != 2'd0);
    assign o_item        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

[rtl/xxh_mul.sv]
// Iterative 64x64 multiplier keeping the low 64 product bits, built on one
// 32x32 multiplier over three steps. Uses the request/response types of xxh_pkg.
`default_nettype none

module xxh_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xxh_pkg::t_mul_req i_req,
    output xxh_pkg::t_mul_rsp      o_rsp
);

    logic [63:0] r_a, r_b, r_acc;
    logic [1:0]  r_step;
    logic        r_run, r_done;
    logic [31:0] w_x, w_y;
    logic [63:0] w_prod;

    // Step 0: low x low, step 1: low x high, step 2: high x low.
    always_comb begin
        w_x = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
        w_y = (r_step == 2'd1) ? r_b[63:32] : r_b[31:0];
    end

    assign w_prod = w_x * w_y;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_run) begin
            if (r_step == 2'd0) begin
                r_acc <= w_prod;
            end else begin
                r_acc <= r_acc + {w_prod[31:0], 32'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= r_run && (r_step == 2'd2);
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= 2'd0;
            end else if (r_run) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

`default_nettype wire

[rtl/xxh_back.sv]
// Back end of the hasher: sequencer for lane rounds, final merge, tail folding
// and avalanche, plus the digest output register. Uses xxh_pkg and drives xxh_mul.
`default_nettype none

module xxh_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [63:0]       i_seed,
    input  wire logic              i_valid,
    input  wire xxh_pkg::t_item    i_item,
    output logic                   o_pop,
    output xxh_pkg::t_mul_req      o_mreq,
    input  wire xxh_pkg::t_mul_rsp i_mrsp,
    output logic                   o_valid,
    output logic [63:0]            o_digest,
    input  wire logic              i_ready
);

    xxh_pkg::t_bstate r_state, n_state;
    logic [1:0]  r_i, n_i;
    logic [63:0] r_lane [4];
    logic [63:0] n_lane [4];
    logic [63:0] r_pend [3];
    logic [63:0] n_pend [3];
    logic [1:0]  r_pcnt, n_pcnt;
    logic [63:0] r_total, n_total;
    logic        r_taken, n_taken;
    logic [63:0] r_part, n_part;
    logic [3:0]  r_c, n_c;
    logic        r_last, n_last;
    logic [63:0] r_t, n_t;
    logic [63:0] r_h, n_h;
    logic        r_mbusy, n_mbusy;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_odata, n_odata;
    logic        w_mul, w_load;
    logic [63:0] w_ma, w_mb, w_word;

    assign w_word = (r_i == xxh_pkg::LAST_LANE) ? r_part : r_pend[r_i];

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_lane   = r_lane;
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_total  = r_total;
        n_taken  = r_taken;
        n_part   = r_part;
        n_c      = r_c;
        n_last   = r_last;
        n_t      = r_t;
        n_h      = r_h;
        n_odata  = r_odata;
        o_pop    = 1'b0;
        w_mul    = 1'b0;
        w_load   = 1'b0;
        w_ma     = r_h;
        w_mb     = xxh_pkg::P1;

        unique case (r_state)
            xxh_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_total = r_total + {60'b0, i_item.cnt};
                    n_part  = i_item.word;
                    n_last  = i_item.last;
                    n_c     = (i_item.cnt == xxh_pkg::FULL_COUNT) ? 4'd0 : i_item.cnt;
                    if (i_item.cnt == xxh_pkg::FULL_COUNT) begin
                        if (r_pcnt != xxh_pkg::STRIPE_HELD) begin
                            n_pend[r_pcnt] = i_item.word;
                            n_pcnt  = r_pcnt + 2'd1;
                            n_state = i_item.last ? xxh_pkg::ST_FIN : xxh_pkg::ST_IDLE;
                        end else begin
                            if (!r_taken) begin
                                n_lane[0] = i_seed + xxh_pkg::P1 + xxh_pkg::P2;
                                n_lane[1] = i_seed + xxh_pkg::P2;
                                n_lane[2] = i_seed;
                                n_lane[3] = i_seed - xxh_pkg::P1;
                            end
                            n_i     = 2'd0;
                            n_state = xxh_pkg::ST_RND_A;
                        end
                    end else begin
                        n_state = xxh_pkg::ST_FIN;
                    end
                end
            end
            xxh_pkg::ST_RND_A: begin
                w_mul = 1'b1;
                w_ma  = w_word;
                w_mb  = xxh_pkg::P2;
                if (i_mrsp.done) begin
                    n_t     = xxh_pkg::rotl(r_lane[r_i] + i_mrsp.p, 31);
                    n_state = xxh_pkg::ST_RND_B;
                end
            end
            xxh_pkg::ST_RND_B: begin
                w_mul = 1'b1;
                w_ma  = r_t;
                if (i_mrsp.done) begin
                    n_lane[r_i] = i_mrsp.p;
                    if (r_i == xxh_pkg::LAST_LANE) begin
                        n_pcnt  = 2'd0;
                        n_taken = 1'b1;
                        n_state = r_last ? xxh_pkg::ST_FIN : xxh_pkg::ST_IDLE;
                    end else begin
                        n_i     = r_i + 2'd1;
                        n_state = xxh_pkg::ST_RND_A;
                    end
                end
            end
            xxh_pkg::ST_FIN: begin
                if (r_taken) begin
                    n_h     = '0;
                    n_i     = 2'd0;
                    n_state = xxh_pkg::ST_MERGE;
                end else begin
                    n_h     = i_seed + xxh_pkg::P5;
                    n_state = xxh_pkg::ST_LEN;
                end
            end
            xxh_pkg::ST_MERGE: begin
                n_h = r_h + xxh_pkg::merge_rot(r_lane[r_i], r_i);
                n_i = r_i + 2'd1;
                if (r_i == xxh_pkg::LAST_LANE) begin
                    n_state = xxh_pkg::ST_FL_A;
                end
            end
            xxh_pkg::ST_FL_A: begin
                w_mul = 1'b1;
                w_ma  = r_lane[r_i];
                w_mb  = xxh_pkg::P2;
                if (i_mrsp.done) begin
                    n_t     = xxh_pkg::rotl(i_mrsp.p, 31);
                    n_state = xxh_pkg::ST_FL_B;
                end
            end
            xxh_pkg::ST_FL_B: begin
                w_mul = 1'b1;
                w_ma  = r_t;
                if (i_mrsp.done) begin
                    n_h     = r_h ^ i_mrsp.p;
                    n_state = xxh_pkg::ST_FL_C;
                end
            end
            xxh_pkg::ST_FL_C: begin
                w_mul = 1'b1;
                w_ma  = r_h;
                if (i_mrsp.done) begin
                    n_h = i_mrsp.p + xxh_pkg::P4;
                    n_i = r_i + 2'd1;
                    n_state = (r_i == xxh_pkg::LAST_LANE) ? xxh_pkg::ST_LEN
                                                          : xxh_pkg::ST_FL_A;
                end
            end
            xxh_pkg::ST_LEN: begin
                n_h     = r_h + r_total;
                n_i     = 2'd0;
                n_state = xxh_pkg::ST_PW_CHK;
            end
            xxh_pkg::ST_PW_CHK: begin
                n_state = (r_i < r_pcnt) ? xxh_pkg::ST_PW_A : xxh_pkg::ST_Q_CHK;
            end
            xxh_pkg::ST_PW_A: begin
                w_mul = 1'b1;
                w_ma  = w_word;
                w_mb  = xxh_pkg::P2;
                if (i_mrsp.done) begin
                    n_t     = xxh_pkg::rotl(i_mrsp.p, 31);
                    n_state = xxh_pkg::ST_PW_B;
                end
            end
            xxh_pkg::ST_PW_B: begin
                w_mul = 1'b1;
                w_ma  = r_t;
                if (i_mrsp.done) begin
                    n_h     = r_h ^ i_mrsp.p;
                    n_state = xxh_pkg::ST_PW_C;
                end
            end
            xxh_pkg::ST_PW_C: begin
                w_mul = 1'b1;
                w_ma  = xxh_pkg::rotl(r_h, 27);
                if (i_mrsp.done) begin
                    n_h     = i_mrsp.p + xxh_pkg::P4;
                    n_i     = r_i + 2'd1;
                    n_state = xxh_pkg::ST_PW_CHK;
                end
            end
            xxh_pkg::ST_Q_CHK: begin
                n_state = (r_c >= 4'd4) ? xxh_pkg::ST_Q_A : xxh_pkg::ST_B_CHK;
            end
            xxh_pkg::ST_Q_A: begin
                w_mul = 1'b1;
                w_ma  = {32'b0, r_part[31:0]};
                if (i_mrsp.done) begin
                    n_h     = r_h ^ i_mrsp.p;
                    n_state = xxh_pkg::ST_Q_B;
                end
            end
            xxh_pkg::ST_Q_B: begin
                w_mul = 1'b1;
                w_ma  = xxh_pkg::rotl(r_h, 23);
                w_mb  = xxh_pkg::P2;
                if (i_mrsp.done) begin
                    n_h     = i_mrsp.p + xxh_pkg::P3;
                    n_part  = r_part >> 32;
                    n_c     = r_c - 4'd4;
                    n_state = xxh_pkg::ST_B_CHK;
                end
            end
            xxh_pkg::ST_B_CHK: begin
                n_state = (r_c != 4'd0) ? xxh_pkg::ST_BY_A : xxh_pkg::ST_AV_A;
            end
            xxh_pkg::ST_BY_A: begin
                w_mul = 1'b1;
                w_ma  = {56'b0, r_part[7:0]};
                w_mb  = xxh_pkg::P5;
                if (i_mrsp.done) begin
                    n_h     = r_h ^ i_mrsp.p;
                    n_state = xxh_pkg::ST_BY_B;
                end
            end
            xxh_pkg::ST_BY_B: begin
                w_mul = 1'b1;
                w_ma  = xxh_pkg::rotl(r_h, 11);
                if (i_mrsp.done) begin
                    n_h     = i_mrsp.p;
                    n_part  = r_part >> 8;
                    n_c     = r_c - 4'd1;
                    n_state = xxh_pkg::ST_B_CHK;
                end
            end
            xxh_pkg::ST_AV_A: begin
                w_mul = 1'b1;
                w_ma  = r_h ^ (r_h >> 33);
                w_mb  = xxh_pkg::P2;
                if (i_mrsp.done) begin
                    n_h     = i_mrsp.p;
                    n_state = xxh_pkg::ST_AV_B;
                end
            end
            xxh_pkg::ST_AV_B: begin
                w_mul = 1'b1;
                w_ma  = r_h ^ (r_h >> 29);
                w_mb  = xxh_pkg::P3;
                if (i_mrsp.done) begin
                    n_h     = i_mrsp.p;
                    n_state = xxh_pkg::ST_OUT;
                end
            end
            xxh_pkg::ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    w_load  = 1'b1;
                    n_odata = r_h ^ (r_h >> 32);
                    n_pcnt  = 2'd0;
                    n_total = '0;
                    n_taken = 1'b0;
                    n_state = xxh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = xxh_pkg::ST_IDLE;
            end
        endcase

        o_mreq.start = w_mul && !r_mbusy;
        o_mreq.a     = w_ma;
        o_mreq.b     = w_mb;
        n_mbusy      = o_mreq.start ? 1'b1 : (i_mrsp.done ? 1'b0 : r_mbusy);
        n_ovalid     = w_load ? 1'b1 : (r_ovalid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        r_lane  <= n_lane;
        r_pend  <= n_pend;
        r_part  <= n_part;
        r_t     <= n_t;
        r_h     <= n_h;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= xxh_pkg::ST_IDLE;
            r_i      <= 2'd0;
            r_pcnt   <= 2'd0;
            r_total  <= '0;
            r_taken  <= 1'b0;
            r_c      <= 4'd0;
            r_last   <= 1'b0;
            r_mbusy  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_pcnt   <= n_pcnt;
            r_total  <= n_total;
            r_taken  <= n_taken;
            r_c      <= n_c;
            r_last   <= n_last;
            r_mbusy  <= n_mbusy;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_digest = r_odata;

`ifndef ASSERT_OFF
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mrsp.done |-> r_mbusy)
        else $error("multiplier result arrived with no request outstanding");

    a_clear_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_total == 64'd0 && r_pcnt == 2'd0 && !r_taken))
        else $error("message state not cleared after digest");

    a_tail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c <= xxh_pkg::FULL_COUNT)
        else $error("tail byte count out of range");

    a_stripe_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xxh_pkg::ST_RND_A) |-> (r_pcnt == xxh_pkg::STRIPE_HELD))
        else $error("lane round started without a full stripe");
`endif

endmodule

`default_nettype wire
